[hw/rtl/msss_pkg.sv]
// shared types, widths and codes for the masked candidate snap select block
package msss_pkg;

	localparam int TARGET_DEPTH = 1024;
	localparam int COORD_BITS   = 24;
	localparam int ADDR_BITS    = $clog2(TARGET_DEPTH);
	localparam int INDEX_BITS   = 10;
	localparam int COUNT_BITS   = 11;
	localparam int DIST_BITS    = 52;
	localparam int MAG_BITS     = COORD_BITS + 1;
	localparam int SQ_BITS      = 2 * MAG_BITS;
	localparam int SUM_BITS     = SQ_BITS + 2;
	localparam int WIDE_BITS    = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DAT_BITS = 11;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SNAP_MODE          = 3'd0,
		REG_USE_POINT_MASK     = 3'd1,
		REG_INVERT_POINT_MASK  = 3'd2,
		REG_USE_TARGET_MASK    = 3'd3,
		REG_INVERT_TARGET_MASK = 3'd4,
		REG_TARGET_COUNT       = 3'd5
	} cfg_reg_t;

	localparam logic [1:0] MODE_LEAST   = 2'd0;
	localparam logic [1:0] MODE_NEAREST = 2'd1;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic                         kind;
		logic [INDEX_BITS-1:0]        entry_index;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] pos_z;
		logic                         tag;
		logic                         has_candidate;
		logic                         last_candidate;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic signed [COORD_BITS-1:0] out_z;
		logic                         snapped;
	} out_item_t;

	typedef struct packed {
		logic                  tag;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
	} target_t;

	localparam int TARGET_BITS = $bits(target_t);

endpackage

[hw/rtl/msss_ram.sv]
// generic single-clock ram, one write port and one registered read port
module msss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/msss_dist.sv]
// squared distance unit: registered squares, then a capped sum
module msss_dist (
	input  logic                           clk,
	input  logic [msss_pkg::COORD_BITS-1:0] point_x,
	input  logic [msss_pkg::COORD_BITS-1:0] point_y,
	input  logic [msss_pkg::COORD_BITS-1:0] point_z,
	input  msss_pkg::target_t              target,
	output logic [msss_pkg::DIST_BITS-1:0]  distance
);
	import msss_pkg::*;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	logic [SQ_BITS-1:0]   sq_x_s2, sq_y_s2, sq_z_s2;
	logic [SUM_BITS-1:0]  sum;
	logic [WIDE_BITS-1:0] sum_wide;

	function automatic logic [SQ_BITS-1:0] square_diff(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		logic [MAG_BITS-1:0] diff;
		logic [MAG_BITS-1:0] mag;
		diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		mag  = diff[MAG_BITS-1] ? (~diff + 1'b1) : diff;
		return SQ_BITS'(mag) * SQ_BITS'(mag);
	endfunction

	always_ff @(posedge clk) begin
		sq_x_s2 <= square_diff(point_x, target.x);
		sq_y_s2 <= square_diff(point_y, target.y);
		sq_z_s2 <= square_diff(point_z, target.z);
	end

	assign sum      = SUM_BITS'(sq_x_s2) + SUM_BITS'(sq_y_s2) + SUM_BITS'(sq_z_s2);
	assign sum_wide = WIDE_BITS'(sum);
	assign distance = (sum_wide > WIDE_BITS'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(sum);

endmodule

[hw/rtl/masked_candidate_snap_select.sv]
// top level: target table, candidate selection and result register
// a load writes the table on accept and the next item is taken in the following cycle
// a candidate passes through table read, squaring, compare against the running best
// the last candidate of a point adds an emit step, after a fetch step when the winner
// is read back from the table; out_valid rises from the emit step, later while held
// arst_n clears config, running best and valids; the target table itself is not cleared
module masked_candidate_snap_select (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  msss_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output msss_pkg::out_item_t               out_data,
	input  logic                              cfg_we,
	input  logic [msss_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [msss_pkg::CFG_DAT_BITS-1:0] cfg_data
);
	import msss_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SQUARE = 5'b00010,
		ST_UPDATE = 5'b00100,
		ST_FETCH  = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t state_q;

	logic [1:0]            snap_mode_q;
	logic                  use_point_mask_q;
	logic                  invert_point_mask_q;
	logic                  use_target_mask_q;
	logic                  invert_target_mask_q;
	logic [COUNT_BITS-1:0] target_count_q;

	logic [INDEX_BITS-1:0] best_index_q;
	logic [DIST_BITS-1:0]  best_dist_q;
	logic                  found_q;

	in_item_t  item_q;
	out_item_t res_q;
	out_item_t out_q;
	logic      out_valid_q;
	logic      elig_s2;

	logic                 accept;
	logic                 ram_we;
	logic [ADDR_BITS-1:0] ram_raddr;
	target_t              ram_wdata;
	target_t              ram_rdata;
	logic [DIST_BITS-1:0] distance;

	logic                  point_masked;
	logic                  idx_in_range;
	logic                  target_masked;
	logic                  take;
	logic [INDEX_BITS-1:0] nxt_index;
	logic                  nxt_found;
	logic                  out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// loads go straight into the table in their accept cycle
	assign ram_we    = accept && (in_data.kind == KIND_LOAD) &&
	                   (32'(in_data.entry_index) < TARGET_DEPTH);
	assign ram_wdata = '{tag: in_data.tag, x: in_data.pos_x, y: in_data.pos_y,
	                     z: in_data.pos_z};
	assign ram_raddr = (state_q == ST_UPDATE) ? ADDR_BITS'(nxt_index)
	                                          : ADDR_BITS'(in_data.entry_index);

	msss_ram #(
		.WIDTH(TARGET_BITS),
		.DEPTH(TARGET_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_BITS'(in_data.entry_index)),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	msss_dist u_dist (
		.clk      (clk),
		.point_x  (item_q.pos_x),
		.point_y  (item_q.pos_y),
		.point_z  (item_q.pos_z),
		.target   (ram_rdata),
		.distance (distance)
	);

	assign point_masked  = use_point_mask_q && (item_q.tag == invert_point_mask_q);
	assign idx_in_range  = ({1'b0, item_q.entry_index} < target_count_q) &&
	                       (32'(item_q.entry_index) < TARGET_DEPTH);
	assign target_masked = use_target_mask_q && (ram_rdata.tag == invert_target_mask_q);

	always_comb begin
		take = 1'b0;
		if (elig_s2) begin
			if (snap_mode_q == MODE_LEAST) begin
				take = !found_q || (item_q.entry_index < best_index_q);
			end else begin
				take = !found_q || (distance < best_dist_q);
			end
		end
		nxt_index = take ? item_q.entry_index : best_index_q;
		nxt_found = found_q || take;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && (in_data.kind == KIND_QUERY)) begin
			item_q <= in_data;
		end
		if (state_q == ST_SQUARE) begin
			elig_s2 <= item_q.has_candidate && !point_masked &&
			           ((snap_mode_q == MODE_LEAST) || (snap_mode_q == MODE_NEAREST)) &&
			           idx_in_range && !target_masked;
		end
		if (state_q == ST_UPDATE) begin
			res_q <= '{out_x: item_q.pos_x, out_y: item_q.pos_y, out_z: item_q.pos_z,
			           snapped: 1'b0};
		end else if (state_q == ST_FETCH) begin
			res_q <= '{out_x: ram_rdata.x, out_y: ram_rdata.y, out_z: ram_rdata.z,
			           snapped: 1'b1};
		end
		if ((state_q == ST_EMIT) && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_mode_q          <= '0;
			use_point_mask_q     <= 1'b0;
			invert_point_mask_q  <= 1'b0;
			use_target_mask_q    <= 1'b0;
			invert_target_mask_q <= 1'b0;
			target_count_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SNAP_MODE:          snap_mode_q          <= cfg_data[1:0];
				REG_USE_POINT_MASK:     use_point_mask_q     <= cfg_data[0];
				REG_INVERT_POINT_MASK:  invert_point_mask_q  <= cfg_data[0];
				REG_USE_TARGET_MASK:    use_target_mask_q    <= cfg_data[0];
				REG_INVERT_TARGET_MASK: invert_target_mask_q <= cfg_data[0];
				REG_TARGET_COUNT:       target_count_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			best_index_q <= '0;
			best_dist_q  <= '0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (in_data.kind == KIND_QUERY)) begin
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (item_q.last_candidate) begin
						best_index_q <= '0;
						best_dist_q  <= '0;
						found_q      <= 1'b0;
						// winner position is read back from the table
						state_q      <= (nxt_found && !point_masked) ? ST_FETCH : ST_EMIT;
					end else begin
						best_index_q <= nxt_index;
						found_q      <= nxt_found;
						if (take && (snap_mode_q == MODE_NEAREST)) begin
							best_dist_q <= distance;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hw/rtl/msss_checker.sv]
// port-level checker for the snap select block, bound to the top level
module msss_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input msss_pkg::in_item_t                in_data,
	input logic                              out_valid,
	input logic                              out_stall,
	input msss_pkg::out_item_t               out_data,
	input logic                              cfg_we,
	input logic [msss_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input logic [msss_pkg::CFG_DAT_BITS-1:0] cfg_data
);
	import msss_pkg::*;

	// a stalled result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// the block is busy in the cycle after it accepts a query transaction
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.kind == KIND_QUERY) |=> in_stall)
		else $error("input taken again right after a query transaction");

	// no new result appears in the cycle after any input transaction
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared directly after an input transaction");

	// results are only produced while the input side is held off
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result produced while input side was open");

	// the user must make register writes only while the block is idle; the block does not enforce it
	a_cfg_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_stall && !$isunknown({cfg_index, cfg_data}))
		else $error("register write while busy or with unknown index or data");

endmodule

bind masked_candidate_snap_select msss_checker u_msss_checker (.*);
